[design/mdu_pkg.sv]
// Shared types and constants for the RV32M multiply/divide unit.
package mdu_pkg;

    localparam int unsigned XLEN = 32;

    typedef logic [2:0] func_t;

    localparam func_t FUNC_MUL    = 3'd0;
    localparam func_t FUNC_MULH   = 3'd1;
    localparam func_t FUNC_MULHSU = 3'd2;
    localparam func_t FUNC_MULHU  = 3'd3;
    localparam func_t FUNC_DIV    = 3'd4;
    localparam func_t FUNC_DIVU   = 3'd5;
    localparam func_t FUNC_REM    = 3'd6;
    localparam func_t FUNC_REMU   = 3'd7;

    // Control that travels with a transaction down the pipeline.
    typedef struct packed {
        logic        is_div;
        logic        want_high;
        logic        want_rem;
        logic        neg_q;
        logic        neg_r;
        logic        div_zero;
        logic [XLEN-1:0] dividend;
    } mdu_ctrl_t;

endpackage

[design/multiply_divide_unit_rv32m.sv]
// Top level of the pipelined RV32M multiply/divide unit.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_ready, func, operand_a, operand_b | into unit
//  out     | out_valid, out_ready, result, divide_by_zero   | out of unit
//
// 35 register stages: one operand stage, one seed stage, 32 stages that each
// retire one quotient bit or one multiplier bit, and the output register, which
// also applies signs, the zero-divisor answer and the half select. A new
// transaction enters every cycle unless the output stalls; a stalled output
// holds the whole pipeline. Reset clears only the valid bits.
module multiply_divide_unit_rv32m
    import mdu_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [2:0]      func,
    input  logic [XLEN-1:0] operand_a,
    input  logic [XLEN-1:0] operand_b,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [XLEN-1:0] result,
    output logic            divide_by_zero
);

    localparam int unsigned NSTG = XLEN;

    logic            adv;
    logic            op_valid_reg;
    mdu_ctrl_t       op_ctrl_reg;
    logic [XLEN-1:0] op_a_reg;
    logic [XLEN-1:0] op_b_reg;
    logic            op_sa_reg;
    logic            op_sb_reg;

    logic            st_valid_reg [NSTG+1];
    mdu_ctrl_t       st_ctrl_reg  [NSTG+1];
    logic [XLEN-1:0] st_rem_reg   [NSTG+1];
    logic [XLEN-1:0] st_quo_reg   [NSTG+1];
    logic [XLEN-1:0] st_b_reg     [NSTG+1];
    logic [2*XLEN+1:0] st_prod_reg [NSTG+1];

    logic [XLEN-1:0] res_next;
    logic            out_valid_reg;
    logic [XLEN-1:0] result_reg;
    logic            dbz_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // Operand stage: register operands and sign flags, and decode control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            op_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            logic sa;
            logic sb;
            logic sgn;
            sgn = (func == FUNC_DIV) || (func == FUNC_REM);
            sa  = operand_a[XLEN-1] && (sgn || func == FUNC_MULH || func == FUNC_MULHSU);
            sb  = operand_b[XLEN-1] && (sgn || func == FUNC_MULH);
            op_sa_reg <= sa;
            op_sb_reg <= sb;
            op_ctrl_reg.is_div    <= func[2];
            op_ctrl_reg.want_high <= func != FUNC_MUL;
            op_ctrl_reg.want_rem  <= func[1];
            op_ctrl_reg.neg_q     <= sa ^ sb;
            op_ctrl_reg.neg_r     <= sa;
            op_ctrl_reg.div_zero  <= func[2] && (operand_b == '0);
            op_ctrl_reg.dividend  <= operand_a;
            op_a_reg <= operand_a;
            op_b_reg <= operand_b;
        end
    end

    // Stage 0 takes magnitudes and seeds the divider or the multiplier.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NSTG; i++)
            begin
                st_valid_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            st_valid_reg[0] <= op_valid_reg;
            for (int i = 1; i <= NSTG; i++)
            begin
                st_valid_reg[i] <= st_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            logic [XLEN-1:0] ma;
            logic [XLEN-1:0] mb;
            ma = op_sa_reg ? (XLEN)'(0 - op_a_reg) : op_a_reg;
            mb = op_sb_reg ? (XLEN)'(0 - op_b_reg) : op_b_reg;
            st_ctrl_reg[0] <= op_ctrl_reg;
            st_rem_reg[0]  <= '0;
            st_quo_reg[0]  <= op_ctrl_reg.is_div ? ma : op_a_reg;
            st_b_reg[0]    <= op_ctrl_reg.is_div ? mb : op_b_reg;
            st_prod_reg[0] <= {op_sb_reg, op_sa_reg, (2*XLEN)'(0)};
            for (int i = 1; i <= NSTG; i++)
            begin
                logic [XLEN:0]   trial;
                logic [XLEN-1:0] rsh;
                logic [XLEN-1:0] a;
                logic [XLEN-1:0] b;
                logic [2*XLEN+1:0] p;
                logic [2*XLEN-1:0] acc;
                a = st_quo_reg[i-1];
                b = st_b_reg[i-1];
                p = st_prod_reg[i-1];
                st_ctrl_reg[i] <= st_ctrl_reg[i-1];
                st_b_reg[i]    <= b;
                if (st_ctrl_reg[i-1].is_div)
                begin
                    rsh   = {st_rem_reg[i-1][XLEN-2:0], a[XLEN-1]};
                    trial = {st_rem_reg[i-1][XLEN-1], rsh} - {1'b0, b};
                    if (!trial[XLEN])
                    begin
                        st_rem_reg[i] <= trial[XLEN-1:0];
                        st_quo_reg[i] <= {a[XLEN-2:0], 1'b1};
                    end
                    else
                    begin
                        st_rem_reg[i] <= rsh;
                        st_quo_reg[i] <= {a[XLEN-2:0], 1'b0};
                    end
                    st_prod_reg[i] <= p;
                end
                else
                begin
                    // Shift-add one bit of a per stage; sign weights fold in as
                    // subtracting the top partial product (two's complement).
                    acc = p[2*XLEN-1:0];
                    if (a[i-1])
                    begin
                        if (i == NSTG && p[2*XLEN])
                        begin
                            acc = acc - ({(XLEN)'(0), b} << (i - 1));
                        end
                        else
                        begin
                            acc = acc + ({(XLEN)'(0), b} << (i - 1));
                        end
                    end
                    if (i == NSTG && p[2*XLEN+1])
                    begin
                        acc = acc - ({(XLEN)'(0), a} << XLEN);
                    end
                    st_prod_reg[i] <= {p[2*XLEN+1:2*XLEN], acc};
                    st_rem_reg[i]  <= st_rem_reg[i-1];
                    st_quo_reg[i]  <= a;
                end
            end
        end
    end

    // Fixup: signs, zero divisor, half select.
    always_comb
    begin
        mdu_ctrl_t c;
        c = st_ctrl_reg[NSTG];
        if (!c.is_div)
        begin
            res_next = c.want_high ? st_prod_reg[NSTG][2*XLEN-1:XLEN]
                                   : st_prod_reg[NSTG][XLEN-1:0];
        end
        else if (c.div_zero)
        begin
            res_next = c.want_rem ? c.dividend : '1;
        end
        else if (c.want_rem)
        begin
            res_next = c.neg_r ? (XLEN)'(0 - st_rem_reg[NSTG]) : st_rem_reg[NSTG];
        end
        else
        begin
            res_next = c.neg_q ? (XLEN)'(0 - st_quo_reg[NSTG]) : st_quo_reg[NSTG];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= st_valid_reg[NSTG];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= res_next;
            dbz_reg    <= st_ctrl_reg[NSTG].is_div && st_ctrl_reg[NSTG].div_zero;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result         = result_reg;
    assign divide_by_zero = dbz_reg;

endmodule

[verif/mdu_checker.sv]
// Checker for the RV32M multiply/divide unit: predicts each result and compares it.
`timescale 1ns / 100ps
module mdu_checker
    import mdu_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_ready,
    input  logic [2:0]      func,
    input  logic [XLEN-1:0] operand_a,
    input  logic [XLEN-1:0] operand_b,
    input  logic            out_valid,
    input  logic            out_ready,
    input  logic [XLEN-1:0] result,
    input  logic            divide_by_zero,
    output int              fail_count,
    output int              pending
);

    typedef struct packed {
        logic [XLEN-1:0] value;
        logic            dz;
    } mdu_answer_t;

    mdu_answer_t answers_due[$];

    function automatic mdu_answer_t compute_answer(func_t op, logic [31:0] a, logic [31:0] b);
        mdu_answer_t ans;
        logic [63:0] prod;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        logic [31:0] r;
        logic        na;
        logic        nb;
        ans.dz = 1'b0;
        ans.value = '0;
        na = a[31];
        nb = b[31];
        ma = na ? -a : a;
        mb = nb ? -b : b;
        case (op)
            FUNC_MUL:    begin prod = {32'd0, a} * {32'd0, b}; ans.value = prod[31:0]; end
            FUNC_MULH:   begin prod = {{32{na}}, a} * {{32{nb}}, b}; ans.value = prod[63:32]; end
            FUNC_MULHSU: begin prod = {{32{na}}, a} * {32'd0, b}; ans.value = prod[63:32]; end
            FUNC_MULHU:  begin prod = {32'd0, a} * {32'd0, b}; ans.value = prod[63:32]; end
            default:
            begin
                if (b == 0)
                begin
                    ans.dz = 1'b1;
                    ans.value = (op == FUNC_DIV || op == FUNC_DIVU) ? '1 : a;
                end
                else if (op == FUNC_DIVU)
                    ans.value = a / b;
                else if (op == FUNC_REMU)
                    ans.value = a % b;
                else
                begin
                    q = ma / mb;
                    r = ma % mb;
                    if (op == FUNC_DIV)
                        ans.value = (na != nb) ? -q : q;
                    else
                        ans.value = na ? -r : r;
                end
            end
        endcase
        return ans;
    endfunction

    assign pending = answers_due.size();

    initial fail_count = 0;

    always @(posedge clk)
    begin
        mdu_answer_t exp_ans;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                answers_due.push_back(compute_answer(func, operand_a, operand_b));
            if (out_valid && out_ready)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("unexpected result %h", result);
                    fail_count++;
                end
                else
                begin
                    exp_ans = answers_due.pop_front();
                    if (result !== exp_ans.value)
                    begin
                        $error("result: expected %h actual %h", exp_ans.value, result);
                        fail_count++;
                    end
                    if (divide_by_zero !== exp_ans.dz)
                    begin
                        $error("divide_by_zero: expected %b actual %b", exp_ans.dz,
                               divide_by_zero);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

[verif/multiply_divide_unit_rv32m_tb.sv]
// Testbench top for the RV32M multiply/divide unit: stimulus, idling and verdict.
`timescale 1ns / 100ps
module multiply_divide_unit_rv32m_tb;
    import mdu_pkg::*;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    logic [2:0]      func;
    logic [XLEN-1:0] operand_a;
    logic [XLEN-1:0] operand_b;
    logic            out_valid;
    logic            out_ready;
    logic [XLEN-1:0] result;
    logic            divide_by_zero;
    int              fail_count;
    int              pending;
    logic            calm;

    multiply_divide_unit_rv32m i_dut (.*);

    mdu_checker i_checker (.*);

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        out_ready <= calm || ($urandom_range(99) >= 13);

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(7))
            0: return 32'h0;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(15);
            5: return -$urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_op(func_t op, logic [31:0] a, logic [31:0] b);
        while (!calm && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        func <= op;
        operand_a <= a;
        operand_b <= b;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    initial
    begin
        func_t op;
        int    drain;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        func = FUNC_MUL;
        operand_a = '0;
        operand_b = '0;
        calm = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (int k = 0; k < 8; k++)
        begin
            op = func_t'(k);
            send_op(op, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            send_op(op, 32'h8000_0000, 32'h0);
        end
        send_op(FUNC_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        send_op(FUNC_REM, 32'h8000_0000, 32'hFFFF_FFFF);
        send_op(FUNC_DIV, 32'hFFFF_FFF9, 32'h2);
        send_op(FUNC_REM, 32'hFFFF_FFF9, 32'h2);
        send_op(FUNC_REM, 32'h7, 32'hFFFF_FFFE);
        send_op(FUNC_MULH, 32'h8000_0000, 32'h8000_0000);
        send_op(FUNC_MULHSU, 32'h8000_0000, 32'hFFFF_FFFF);
        for (int n = 0; n < 450; n++)
        begin
            calm = (n >= 150 && n < 250);
            op = func_t'($urandom_range(7));
            send_op(op, pick_operand(), pick_operand());
        end
        in_valid <= 1'b0;
        drain = 0;
        while (pending != 0 && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

[sim.f]
design/mdu_pkg.sv
design/multiply_divide_unit_rv32m.sv
verif/mdu_checker.sv
verif/multiply_divide_unit_rv32m_tb.sv
